// ===== rtl/tdr_pkg.sv =====
package tdr_pkg;

    localparam int MAINS_HZ_DEF   = 50;
    localparam int RAMP_SECS_W    = 8;
    localparam int LEVEL_W        = 7;
    localparam int PCT_MAX        = 100;
    localparam int RAMP_SECS_RST  = 2;
    localparam int QUOT_W         = 7;   // quotient never exceeds 100
    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    // register indexes (byte address = 4 * index)
    localparam int REG_RAMP_SECONDS = 0;

    typedef enum logic [1:0] {
        REQ_CROSS  = 2'd0,
        REQ_TARGET = 2'd1,
        REQ_ON     = 2'd2,
        REQ_OFF    = 2'd3
    } t_req;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_cross;
        logic out_free;
    } t_dp_status;

    // power percent -> firing delay
    localparam logic [LEVEL_W-1:0] DELAY_TABLE [0:PCT_MAX] = '{
         7'd0,  7'd0,  7'd0,  7'd0, 7'd13, 7'd14, 7'd16, 7'd17, 7'd18, 7'd19,
        7'd20, 7'd22, 7'd23, 7'd23, 7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29,
        7'd29, 7'd30, 7'd31, 7'd32, 7'd32, 7'd33, 7'd34, 7'd35, 7'd35, 7'd36,
        7'd37, 7'd37, 7'd38, 7'd39, 7'd39, 7'd40, 7'd41, 7'd41, 7'd42, 7'd43,
        7'd43, 7'd44, 7'd45, 7'd45, 7'd46, 7'd47, 7'd47, 7'd48, 7'd49, 7'd50,
        7'd50, 7'd51, 7'd51, 7'd52, 7'd52, 7'd53, 7'd54, 7'd54, 7'd55, 7'd56,
        7'd56, 7'd57, 7'd58, 7'd58, 7'd59, 7'd60, 7'd60, 7'd61, 7'd62, 7'd62,
        7'd63, 7'd64, 7'd64, 7'd65, 7'd66, 7'd67, 7'd67, 7'd68, 7'd69, 7'd70,
        7'd70, 7'd71, 7'd72, 7'd73, 7'd74, 7'd75, 7'd76, 7'd77, 7'd78, 7'd79,
        7'd80, 7'd81, 7'd82, 7'd83, 7'd84, 7'd85, 7'd87, 7'd89, 7'd90, 7'd93,
        7'd100
    };

endpackage

// ===== rtl/tdr_ctrl.sv =====
module tdr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tdr_pkg::t_dp_status i_status,
    output tdr_pkg::t_dp_cmd    o_cmd
);
    import tdr_pkg::*;

    localparam int STEP_W = $clog2(QUOT_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_PUSH
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_step    = '0;
                n_state   = i_status.is_cross ? S_DIV : S_PUSH;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_W'(QUOT_W - 1)) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== rtl/tdr_datapath.sv =====
module tdr_datapath #(
    parameter int MAINS_HZ = tdr_pkg::MAINS_HZ_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tdr_pkg::t_dp_cmd                    i_cmd,
    output tdr_pkg::t_dp_status                 o_status,
    input  logic [1:0]                          i_req_type,
    input  logic [7:0]                          i_power_value,
    input  logic                                i_cfg_we,
    input  logic [tdr_pkg::RAMP_SECS_W-1:0]     i_cfg_data,
    output logic [tdr_pkg::RAMP_SECS_W-1:0]     o_ramp_seconds,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [tdr_pkg::LEVEL_W-1:0]         o_firing_delay,
    output logic [tdr_pkg::LEVEL_W-1:0]         o_present_power,
    output logic [tdr_pkg::LEVEL_W-1:0]         o_target_power,
    output logic                                o_switched_on
);
    import tdr_pkg::*;

    localparam int CYC_MAX = (2 ** RAMP_SECS_W - 1) * 2 * MAINS_HZ;
    localparam int CYC_W   = $clog2(CYC_MAX + 1);
    localparam int PROD_W  = CYC_W + LEVEL_W;
    localparam int HALF_CYCLES_PER_SEC = 2 * MAINS_HZ;

    // ramp state
    logic [RAMP_SECS_W-1:0] r_ramp_secs;
    logic [LEVEL_W-1:0]     r_level, r_goal, r_origin, r_delay;
    logic                   r_on;
    logic [CYC_W-1:0]       r_pos;

    // item being worked on
    t_req                   r_kind;
    logic [7:0]             r_pv;

    // divider
    logic [PROD_W-1:0]      r_rem, r_div;
    logic [QUOT_W-1:0]      r_quot;
    logic                   r_neg;

    // output register
    logic                   r_out_valid;
    logic [LEVEL_W-1:0]     r_o_delay, r_o_level, r_o_goal;
    logic                   r_o_on;

    logic [CYC_W-1:0]       w_cycles, w_cycles_cfg;
    logic [LEVEL_W-1:0]     w_target, w_mag, w_level;
    logic                   w_neg;
    logic [PROD_W-1:0]      w_prod;

    logic [LEVEL_W-1:0]     n_level, n_goal, n_origin, n_delay;
    logic                   n_on;
    logic [CYC_W-1:0]       n_pos;

    assign w_cycles     = CYC_W'(32'(r_ramp_secs) * 32'(HALF_CYCLES_PER_SEC));
    assign w_cycles_cfg = CYC_W'(32'(i_cfg_data) * 32'(HALF_CYCLES_PER_SEC));

    assign w_target = r_on ? r_goal : '0;
    assign w_neg    = (w_target < r_origin);
    assign w_mag    = w_neg ? (r_origin - w_target) : (w_target - r_origin);
    assign w_prod   = {{CYC_W{1'b0}}, w_mag} * {{LEVEL_W{1'b0}}, r_pos};

    // quotient sits at most |target - origin| away from origin, so no wrap
    always_comb begin
        if (w_cycles == '0) begin
            w_level = w_target;
        end else if (r_neg) begin
            w_level = r_origin - r_quot;
        end else begin
            w_level = r_origin + r_quot;
        end
    end

    always_comb begin
        n_level  = r_level;
        n_goal   = r_goal;
        n_origin = r_origin;
        n_delay  = r_delay;
        n_on     = r_on;
        n_pos    = r_pos;
        case (r_kind)
            REQ_CROSS: begin
                n_level = (w_level > LEVEL_W'(PCT_MAX)) ? LEVEL_W'(PCT_MAX) : w_level;
                n_delay = DELAY_TABLE[n_level];
                if (r_pos < w_cycles) begin
                    n_pos = r_pos + 1'b1;
                end
            end
            REQ_TARGET: begin
                n_goal   = (r_pv > 8'(PCT_MAX)) ? LEVEL_W'(PCT_MAX) : r_pv[LEVEL_W-1:0];
                n_origin = r_level;
                n_pos    = '0;
            end
            REQ_ON: begin
                n_on     = 1'b1;
                n_origin = r_level;
                n_pos    = '0;
            end
            REQ_OFF: begin
                n_on     = 1'b0;
                n_origin = r_level;
                n_pos    = '0;
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_secs <= RAMP_SECS_W'(RAMP_SECS_RST);
            r_level     <= '0;
            r_goal      <= '0;
            r_origin    <= '0;
            r_delay     <= '0;
            r_on        <= 1'b0;
            r_pos       <= CYC_W'(RAMP_SECS_RST * HALF_CYCLES_PER_SEC);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ramp_secs <= i_cfg_data;
                r_pos       <= w_cycles_cfg;
            end else if (i_cmd.commit) begin
                r_pos <= n_pos;
            end
            if (i_cmd.commit) begin
                r_level  <= n_level;
                r_goal   <= n_goal;
                r_origin <= n_origin;
                r_delay  <= n_delay;
                r_on     <= n_on;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= t_req'(i_req_type);
            r_pv   <= i_power_value;
        end
        if (i_cmd.mul) begin
            r_rem  <= w_prod;
            r_div  <= PROD_W'({w_cycles, {(QUOT_W-1){1'b0}}});
            r_quot <= '0;
            r_neg  <= w_neg;
        end else if (i_cmd.div_step) begin
            if (r_rem >= r_div) begin
                r_rem  <= r_rem - r_div;
                r_quot <= {r_quot[QUOT_W-2:0], 1'b1};
            end else begin
                r_quot <= {r_quot[QUOT_W-2:0], 1'b0};
            end
            r_div <= r_div >> 1;
        end
        if (i_cmd.commit) begin
            r_o_delay <= n_delay;
            r_o_level <= n_level;
            r_o_goal  <= n_goal;
            r_o_on    <= n_on;
        end
    end

    assign o_status.is_cross = (r_kind == REQ_CROSS);
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign o_ramp_seconds  = r_ramp_secs;
    assign o_out_valid     = r_out_valid;
    assign o_firing_delay  = r_o_delay;
    assign o_present_power = r_o_level;
    assign o_target_power  = r_o_goal;
    assign o_switched_on   = r_o_on;

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LEVEL_W'(PCT_MAX))
        else $error("present level beyond 100");

    a_goal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_goal <= LEVEL_W'(PCT_MAX))
        else $error("goal level beyond 100");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= w_cycles)
        else $error("ramp position past ramp length");

    a_delay_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_delay == DELAY_TABLE[r_level])
        else $error("delay latch out of step with present level");

endmodule

// ===== rtl/triac_dimmer_ramp_unit.sv =====
// Phase-angle triac dimmer with a linear ramp. Each input item is one event
// (zero crossing, new target power, switch on, switch off) and yields exactly
// one result item carrying the firing delay, the present power, the stored
// target and the on flag. Target, on and off events restart the ramp from
// the present power; each zero crossing interpolates toward the target (zero
// when off), looks the power up in the delay table and steps the ramp.
// Timing: an item is taken only while the controller is idle. A non-crossing
// event holds the block through accept, multiply and push, and its result is
// loaded into the output register at the push; a zero crossing holds it also
// through the 7-step restoring divider (one quotient bit a cycle), which runs
// after the multiply, and its result is likewise loaded at the push.
// The result waits in an output register, so the next item is taken while it
// is still stalled; a further result waits for that register to drain. That
// wait stretches the push cycle. ramp_seconds sits at byte address 0; writing
// it ends any ramp in progress. pready is tied high.
module triac_dimmer_ramp_unit #(
    parameter int MAINS_HZ = tdr_pkg::MAINS_HZ_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input items
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_req_type,
    input  logic [7:0]                      i_power_value,
    // result items
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [tdr_pkg::LEVEL_W-1:0]     o_firing_delay,
    output logic [tdr_pkg::LEVEL_W-1:0]     o_present_power,
    output logic [tdr_pkg::LEVEL_W-1:0]     o_target_power,
    output logic                            o_switched_on,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tdr_pkg::PADDR_W-1:0]     paddr,
    input  logic [tdr_pkg::PDATA_W-1:0]     pwdata,
    output logic [tdr_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);
    import tdr_pkg::*;

    t_dp_cmd                w_cmd;
    t_dp_status             w_status;
    logic                   w_cfg_we;
    logic                   w_reg_hit;
    logic [RAMP_SECS_W-1:0] w_ramp_secs;

    // word index is paddr[2]; anything but register 0 is ignored
    assign w_reg_hit = (paddr[PADDR_W-1] == 1'(REG_RAMP_SECONDS));
    assign w_cfg_we  = psel && penable && pwrite && w_reg_hit;
    assign pready    = 1'b1;
    assign prdata    = w_reg_hit ? PDATA_W'(w_ramp_secs) : '0;

    tdr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tdr_datapath #(
        .MAINS_HZ (MAINS_HZ)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_req_type      (i_req_type),
        .i_power_value   (i_power_value),
        .i_cfg_we        (w_cfg_we),
        .i_cfg_data      (pwdata[RAMP_SECS_W-1:0]),
        .o_ramp_seconds  (w_ramp_secs),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_firing_delay  (o_firing_delay),
        .o_present_power (o_present_power),
        .o_target_power  (o_target_power),
        .o_switched_on   (o_switched_on)
    );

endmodule
